@@ rtl/lws_pkg.sv @@
// shared types and constants for the latency window statistics block
package lws_pkg;

  localparam int SAMPLE_W  = 32;
  localparam int COUNT_W   = 20;
  localparam int SUM_W     = 52;
  localparam int ALU_W     = SUM_W + 1;
  localparam int DIV_STEPS = SUM_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;

  localparam logic signed [SAMPLE_W-1:0] MIN_START = SAMPLE_W'(1000000000);
  localparam logic signed [SAMPLE_W-1:0] MAX_START = -SAMPLE_W'(1000000000);

  localparam logic [COUNT_W-1:0] WINDOW_LENGTH_RESET = COUNT_W'(20000);

  // register indexes
  localparam logic REG_WINDOW_LENGTH = 1'b0;
  localparam logic REG_OVERALL_MODE  = 1'b1;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [COUNT_W-1:0] window_length;
    logic               overall_mode;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIN,
    ST_MAX,
    ST_ACC,
    ST_ABS,
    ST_DIV,
    ST_SIGN
  } lws_state_t;

endpackage

@@ rtl/lws_ifs.sv @@
// valid/ready channel interfaces for samples and results
interface lws_sample_if import lws_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] latency_sample;

  modport source (output valid, output latency_sample, input ready);
  modport sink   (input valid, input latency_sample, output ready);
endinterface

interface lws_result_if import lws_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] window_min;
  logic signed [SAMPLE_W-1:0] window_max;
  logic signed [SAMPLE_W-1:0] window_average;

  modport source (output valid, output window_min, output window_max,
                  output window_average, input ready);
  modport sink   (input valid, input window_min, input window_max,
                  input window_average, output ready);
endinterface

@@ rtl/latency_window_statistics_top.sv @@
// top level of the windowed latency statistics block
//
// takes one signed nanosecond latency word per handshake and keeps the
// minimum, the maximum and a 52-bit running sum over a window of
// window_length samples (0 acts as 1); on the window's last sample one
// result word carries min, max and the average, truncated toward zero.
// all datapath arithmetic goes through a single 53-bit add/subtract unit
// under a small sequencer. a sample that does not close the window holds
// the input off after acceptance while the sequencer runs min compare,
// max compare and accumulate, so a new sample is only taken once the last
// is through. a closing sample adds a magnitude step, a 52-step restoring
// divide at one quotient bit per cycle and a sign fix-up before the input
// is ready again. the result sits in an output register, so the block
// keeps taking samples while it waits to be taken, and only stalls if a
// second window closes before the first result is taken.
// registers sit on an apb port: window_length at 0x0 (20 bits, reset
// 20000) and overall_mode at 0x4 (1 bit, reset 1: min/max kept across
// windows; 0 restarts them at +1e9/-1e9 each window). write them only
// while the block is idle.
module latency_window_statistics_top import lws_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  lws_sample_if.sink        sample,
  lws_result_if.source      result
);

  cfg_t             cfg;
  alu_req_t         alu_req;
  logic [ALU_W-1:0] alu_res;

  // configuration registers
  lws_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // the one shared arithmetic unit
  lws_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  // sequencer, statistics registers, divider registers and output register
  lws_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .in_sample (sample.latency_sample),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_min   (result.window_min),
    .out_max   (result.window_max),
    .out_avg   (result.window_average),
    .alu_req   (alu_req),
    .alu_res   (alu_res)
  );

  // a sample keeps the sequencer busy for at least the compare cycles
  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> !sample.ready
  ) else $error("input ready straight after a sample word was taken");

  // a result only appears after the divide and sign fix-up, never right after a take
  a_result_not_early: assert property (
    @(posedge clk) disable iff (rst)
    $rose(result.valid) |-> !$past(sample.valid && sample.ready)
  ) else $error("result word raised directly after a sample word");

  // a window result is only loaded from the sign fix-up, with the input held off
  a_result_while_busy: assert property (
    @(posedge clk) disable iff (rst)
    $rose(result.valid) |-> !$past(sample.ready)
  ) else $error("result word loaded while the sequencer was idle");

endmodule

@@ rtl/lws_cfg.sv @@
// apb register file for window length and overall mode
module lws_cfg import lws_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic reg_index;
  logic wr_en;

  assign reg_index = paddr[2];
  assign wr_en     = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_length <= WINDOW_LENGTH_RESET;
      cfg.overall_mode  <= 1'b1;
    end else if (wr_en) begin
      unique case (reg_index)
        REG_WINDOW_LENGTH: cfg.window_length <= pwdata[COUNT_W-1:0];
        REG_OVERALL_MODE:  cfg.overall_mode  <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_WINDOW_LENGTH: prdata = {{(APB_DW-COUNT_W){1'b0}}, cfg.window_length};
      REG_OVERALL_MODE:  prdata = {{(APB_DW-1){1'b0}}, cfg.overall_mode};
    endcase
  end

endmodule

@@ rtl/lws_alu.sv @@
// shared wide adder/subtractor used for compares, accumulation, negation and division
module lws_alu import lws_pkg::*; (
  input  alu_req_t         req,
  output logic [ALU_W-1:0] res
);

  always_comb begin
    case (req.op)
      ALU_ADD: res = req.a + req.b;
      ALU_SUB: res = req.a - req.b;
      default: res = req.a - req.b;
    endcase
  end

endmodule

@@ rtl/lws_core.sv @@
// sequencer and datapath registers: min, max, running sum and restoring divide
module lws_core import lws_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  cfg_t                       cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_min,
  output logic signed [SAMPLE_W-1:0] out_max,
  output logic signed [SAMPLE_W-1:0] out_avg,
  output alu_req_t                   alu_req,
  input  logic [ALU_W-1:0]           alu_res
);

  lws_state_t state, state_next;

  logic signed [SAMPLE_W-1:0] sample_q;
  logic signed [SAMPLE_W-1:0] min_seen;
  logic signed [SAMPLE_W-1:0] max_seen;
  logic signed [SUM_W-1:0]    running_sum;
  logic [COUNT_W-1:0]         count;
  logic                       close_win;
  logic                       sum_neg;
  logic [SUM_W-1:0]           dq;
  logic [COUNT_W-1:0]         rem;
  logic [STEP_W-1:0]          step;

  logic [COUNT_W-1:0] len_eff;
  logic [COUNT_W-1:0] cnt1;
  logic               closes;
  logic [COUNT_W:0]   trial;
  logic               fits;
  logic               out_free;
  logic               accept;
  logic               last_step;

  function automatic logic [ALU_W-1:0] sext(input logic [SAMPLE_W-1:0] x);
    return {{(ALU_W-SAMPLE_W){x[SAMPLE_W-1]}}, x};
  endfunction

  assign len_eff   = (cfg.window_length == '0) ? COUNT_W'(1) : cfg.window_length;
  assign cnt1      = count + COUNT_W'(1);
  assign closes    = (cnt1 == '0) || (cnt1 >= len_eff);
  assign trial     = {rem, dq[SUM_W-1]};
  assign fits      = !alu_res[ALU_W-1];
  assign out_free  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign last_step = (step == STEP_W'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    alu_req.op  = ALU_SUB;
    alu_req.a   = '0;
    alu_req.b   = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = ST_MIN;
      end
      ST_MIN: begin
        alu_req.a  = sext(sample_q);
        alu_req.b  = sext(min_seen);
        state_next = ST_MAX;
      end
      ST_MAX: begin
        alu_req.a  = sext(max_seen);
        alu_req.b  = sext(sample_q);
        state_next = ST_ACC;
      end
      ST_ACC: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = {running_sum[SUM_W-1], running_sum};
        alu_req.b  = sext(sample_q);
        state_next = close_win ? ST_ABS : ST_IDLE;
      end
      ST_ABS: begin
        alu_req.b  = {running_sum[SUM_W-1], running_sum};
        state_next = ST_DIV;
      end
      ST_DIV: begin
        alu_req.a = {{(ALU_W-COUNT_W-1){1'b0}}, trial};
        alu_req.b = {{(ALU_W-COUNT_W){1'b0}}, len_eff};
        if (last_step) state_next = ST_SIGN;
      end
      ST_SIGN: begin
        alu_req.b = {1'b0, dq};
        if (out_free) state_next = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      min_seen    <= MIN_START;
      max_seen    <= MAX_START;
      running_sum <= '0;
      count       <= '0;
      step        <= '0;
      out_valid   <= 1'b0;
    end else begin
      // load from the sign fix-up, otherwise hold until taken
      out_valid <= (state == ST_SIGN && out_free) || (out_valid && !out_ready);
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (count == '0 && !cfg.overall_mode) begin
              min_seen <= MIN_START;
              max_seen <= MAX_START;
            end
            count <= closes ? '0 : cnt1;
          end
        end
        ST_MIN: if (alu_res[ALU_W-1]) min_seen <= sample_q;
        ST_MAX: if (alu_res[ALU_W-1]) max_seen <= sample_q;
        ST_ACC: running_sum <= alu_res[SUM_W-1:0];
        ST_ABS: begin
          running_sum <= '0;
          step        <= '0;
        end
        ST_DIV: step <= step + STEP_W'(1);
        ST_SIGN: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          sample_q  <= in_sample;
          close_win <= closes;
        end
      end
      ST_ABS: begin
        sum_neg <= running_sum[SUM_W-1];
        dq      <= running_sum[SUM_W-1] ? alu_res[SUM_W-1:0] : running_sum;
        rem     <= '0;
      end
      ST_DIV: begin
        rem <= fits ? alu_res[COUNT_W-1:0] : trial[COUNT_W-1:0];
        dq  <= {dq[SUM_W-2:0], fits};
      end
      ST_SIGN: begin
        if (out_free) begin
          out_min <= min_seen;
          out_max <= max_seen;
          out_avg <= sum_neg ? alu_res[SAMPLE_W-1:0] : dq[SAMPLE_W-1:0];
        end
      end
      default: ;
    endcase
  end

endmodule
